[design/fisp_pkg.sv]
// Package: shared constants, widths and register indexes for the filtered speed PID.
`timescale 1ns / 1ps
package fisp_pkg;

  // Default full-scale duty magnitude
  localparam int DUTY_FULL_SCALE_DEF = 10000;

  // Field widths
  localparam int DATA_W   = 16;
  localparam int DUTY_W   = 15;
  localparam int LIMIT_W  = 14;
  localparam int CFG_IDX_W = 3;

  // Serial multiplier: multiplier bits, multiplicand bits, product bits
  localparam int MULT_W  = 17;
  localparam int MCAND_W = 19;
  localparam int HI_W    = MCAND_W + 1;
  localparam int PROD_W  = HI_W + MULT_W;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_COEFF   = 3'd0,
    REG_SPEED_SETPOINT = 3'd1,
    REG_GAIN_P         = 3'd2,
    REG_GAIN_I         = 3'd3,
    REG_GAIN_D         = 3'd4,
    REG_INTEGRAL_LIMIT = 3'd5,
    REG_OUTPUT_LIMIT   = 3'd6,
    REG_LOOP_ENABLE    = 3'd7
  } cfg_reg_t;

  // Reset values of the configuration registers
  localparam logic [DATA_W-1:0]  FILTER_COEFF_RST   = 16'd32768;
  localparam logic [DATA_W-1:0]  INTEGRAL_LIMIT_RST = 16'd65535;
  localparam logic [LIMIT_W-1:0] OUTPUT_LIMIT_RST   = 14'd10000;

endpackage

[design/filtered_incremental_speed_pid.sv]
// Top level: low-pass filtered encoder speed feeding an incremental PID, bit-serial multiplier.
// Each input transaction runs four serial multiplies (filter, P, I, D), each a load, 17 bit steps
//   and an accumulate; a final state then forms delta and duty once the output register is free.
// A new item is taken only in idle, after the last one is through the single shared shift-add multiplier.
// Input is taken again while a finished result still waits in the output register.
// Reset (rst, synchronous, active high) clears filter/error history, duty accumulator,
//   configuration registers to their defaults and the output valid flag.
`timescale 1ns / 1ps
module filtered_incremental_speed_pid #(
  parameter int DUTY_FULL_SCALE = fisp_pkg::DUTY_FULL_SCALE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [fisp_pkg::DATA_W-1:0]   pulse_count,
  // output channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [fisp_pkg::DATA_W-1:0]   filtered_speed,
  output logic signed [fisp_pkg::DATA_W-1:0]   duty_delta,
  output logic signed [fisp_pkg::DUTY_W-1:0]   duty_out,
  // configuration channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fisp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fisp_pkg::DATA_W-1:0]          cfg_data
);

  localparam int DW = fisp_pkg::DATA_W;
  localparam int MW = fisp_pkg::MULT_W;
  localparam int CW = fisp_pkg::MCAND_W;
  localparam int HW = fisp_pkg::HI_W;
  localparam int PW = fisp_pkg::PROD_W;
  localparam int LW = fisp_pkg::LIMIT_W;
  localparam int UW = fisp_pkg::DUTY_W;
  localparam logic [LW-1:0] FULL = LW'(DUTY_FULL_SCALE);
  localparam logic [4:0] MUL_LAST = 5'(MW - 1);
  localparam logic [DW-1:0] FILTER_ONE = 16'd32768;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_MUL, S_ACC, S_FIN
  } state_t;

  typedef enum logic [1:0] {
    OP_FILT, OP_P, OP_I, OP_D
  } op_t;

  state_t state;
  op_t    op;

  // configuration registers
  logic [DW-1:0]        filter_coeff;
  logic signed [DW-1:0] speed_setpoint;
  logic signed [DW-1:0] gain_p;
  logic signed [DW-1:0] gain_i;
  logic signed [DW-1:0] gain_d;
  logic [DW-1:0]        integral_limit;
  logic [LW-1:0]        output_limit;
  logic                 closed_loop_enable;

  // loop state
  logic signed [DW-1:0]  speed_prev;
  logic signed [DW:0]    error_prev1;
  logic signed [DW:0]    error_prev2;
  logic signed [UW-1:0]  duty_accum;

  // per-item working registers
  logic signed [DW-1:0]  sample;
  logic signed [CW-1:0]  prop_term;
  logic signed [DW:0]    integ_term;
  logic signed [CW-1:0]  deriv_term;
  logic signed [PW-1:0]  sum_acc;

  // serial multiplier
  logic signed [CW-1:0]  mcand;
  logic signed [HW-1:0]  mul_hi;
  logic [MW-1:0]         mul_lo;
  logic [4:0]            mul_cnt;

  logic signed [HW:0]    mul_add;
  logic signed [HW:0]    mul_sum;
  logic signed [PW-1:0]  product;

  logic [MW-1:0]         k_eff;
  logic signed [PW-1:0]  filt_acc;
  logic signed [PW-1:0]  filt_adj;
  logic signed [DW-1:0]  speed_new;
  logic signed [DW:0]    e0_new;
  logic signed [CW-1:0]  prop_new;
  logic signed [CW-1:0]  deriv_new;
  logic signed [DW+1:0]  lim_ext;
  logic signed [DW:0]    integ_new;

  logic signed [CW-1:0]  mcand_load;
  logic [MW-1:0]         mult_load;

  logic signed [PW-1:0]  sum_adj;
  logic signed [PW-9:0]  quot;
  logic signed [DW-1:0]  delta_sat;
  logic signed [UW+1:0]  duty_sum;
  logic [LW-1:0]         duty_lim;
  logic signed [UW-1:0]  duty_new;

  logic in_fire;
  logic out_fire;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  // one shift-add step: add multiplicand on a set bit, subtract on the sign bit
  always_comb begin
    mul_add = '0;
    if (mul_lo[0]) begin
      if (mul_cnt == MUL_LAST) begin
        mul_add = -(HW+1)'(mcand);
      end else begin
        mul_add = (HW+1)'(mcand);
      end
    end
    mul_sum = (HW+1)'(mul_hi) + mul_add;
    product = $signed({mul_hi, mul_lo});
  end

  // filter: acc = 32768*prev + k*(x - prev), truncated toward zero
  always_comb begin
    k_eff     = (filter_coeff > FILTER_ONE) ? MW'(FILTER_ONE) : MW'(filter_coeff);
    filt_acc  = ($signed(PW'(speed_prev)) <<< 15) + product;
    filt_adj  = filt_acc + (filt_acc[PW-1] ? PW'(32767) : PW'(0));
    speed_new = filt_adj[DW+14:15];
    e0_new    = (DW+1)'(speed_setpoint) - (DW+1)'(speed_new);
    prop_new  = CW'(e0_new) - CW'(error_prev1);
    deriv_new = CW'(e0_new) - (CW'(error_prev1) <<< 1) + CW'(error_prev2);
    lim_ext   = $signed({2'b00, integral_limit});
    if ((DW+2)'(e0_new) > lim_ext) begin
      integ_new = lim_ext[DW:0];
    end else if ((DW+2)'(e0_new) < -lim_ext) begin
      integ_new = -$signed(lim_ext[DW:0]);
    end else begin
      integ_new = e0_new;
    end
  end

  // operand select for the next multiply
  always_comb begin
    case (op)
      OP_FILT: begin
        mcand_load = CW'((DW+1)'(sample) - (DW+1)'(speed_prev));
        mult_load  = k_eff;
      end
      OP_P: begin
        mcand_load = prop_term;
        mult_load  = MW'(gain_p);
      end
      OP_I: begin
        mcand_load = CW'(integ_term);
        mult_load  = MW'(gain_i);
      end
      default: begin
        mcand_load = deriv_term;
        mult_load  = MW'(gain_d);
      end
    endcase
  end

  // delta = sum/256 toward zero, saturated, zero when the loop is disabled; duty clamped to the output bound
  always_comb begin
    sum_adj = sum_acc + (sum_acc[PW-1] ? PW'(255) : PW'(0));
    quot    = sum_adj[PW-1:8];
    if (quot > (PW-8)'(32767)) begin
      delta_sat = 16'sh7FFF;
    end else if (quot < -(PW-8)'(32768)) begin
      delta_sat = 16'sh8000;
    end else begin
      delta_sat = quot[DW-1:0];
    end
    if (!closed_loop_enable) begin
      delta_sat = '0;
    end
    duty_lim = (output_limit > FULL) ? FULL : output_limit;
    duty_sum = (UW+2)'(duty_accum) + (UW+2)'(delta_sat);
    if (duty_sum > $signed({3'b000, duty_lim})) begin
      duty_new = $signed({1'b0, duty_lim});
    end else if (duty_sum < -$signed({3'b000, duty_lim})) begin
      duty_new = -$signed({1'b0, duty_lim});
    end else begin
      duty_new = duty_sum[UW-1:0];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_coeff       <= fisp_pkg::FILTER_COEFF_RST;
      speed_setpoint     <= '0;
      gain_p             <= '0;
      gain_i             <= '0;
      gain_d             <= '0;
      integral_limit     <= fisp_pkg::INTEGRAL_LIMIT_RST;
      output_limit       <= fisp_pkg::OUTPUT_LIMIT_RST;
      closed_loop_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (fisp_pkg::cfg_reg_t'(cfg_index))
        fisp_pkg::REG_FILTER_COEFF:   filter_coeff       <= cfg_data;
        fisp_pkg::REG_SPEED_SETPOINT: speed_setpoint     <= $signed(cfg_data);
        fisp_pkg::REG_GAIN_P:         gain_p             <= $signed(cfg_data);
        fisp_pkg::REG_GAIN_I:         gain_i             <= $signed(cfg_data);
        fisp_pkg::REG_GAIN_D:         gain_d             <= $signed(cfg_data);
        fisp_pkg::REG_INTEGRAL_LIMIT: integral_limit     <= cfg_data;
        fisp_pkg::REG_OUTPUT_LIMIT:   output_limit       <= cfg_data[LW-1:0];
        fisp_pkg::REG_LOOP_ENABLE:    closed_loop_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer, serial multiplier and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      op          <= OP_FILT;
      out_valid   <= 1'b0;
      speed_prev  <= '0;
      error_prev1 <= '0;
      error_prev2 <= '0;
      duty_accum  <= '0;
      mul_cnt     <= '0;
    end else begin
      // result valid: set when a result is loaded, cleared when taken
      if (state == S_FIN && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            sample  <= pulse_count;
            sum_acc <= '0;
            op      <= OP_FILT;
            state   <= S_LOAD;
          end
        end
        S_LOAD: begin
          mcand   <= mcand_load;
          mul_hi  <= '0;
          mul_lo  <= mult_load;
          mul_cnt <= '0;
          state   <= S_MUL;
        end
        S_MUL: begin
          mul_hi  <= mul_sum[HW:1];
          mul_lo  <= {mul_sum[0], mul_lo[MW-1:1]};
          mul_cnt <= mul_cnt + 5'd1;
          if (mul_cnt == MUL_LAST) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (op == OP_FILT) begin
            speed_prev  <= speed_new;
            error_prev1 <= e0_new;
            error_prev2 <= error_prev1;
            prop_term   <= prop_new;
            deriv_term  <= deriv_new;
            integ_term  <= integ_new;
            op          <= OP_P;
            state       <= S_LOAD;
          end else begin
            sum_acc <= sum_acc + product;
            if (op == OP_D) begin
              state <= S_FIN;
            end else begin
              op    <= op_t'(op + 2'd1);
              state <= S_LOAD;
            end
          end
        end
        S_FIN: begin
          // wait until the output register is free
          if (!out_valid || out_ready) begin
            filtered_speed <= speed_prev;
            duty_delta     <= delta_sat;
            duty_out       <= duty_new;
            duty_accum     <= duty_new;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[design/fisp_checker.sv]
// Checker: port-level assertions for the filtered speed PID, bound to the top level.
`timescale 1ns / 1ps
module fisp_checker #(
  parameter int DUTY_FULL_SCALE = fisp_pkg::DUTY_FULL_SCALE_DEF
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [fisp_pkg::DATA_W-1:0] filtered_speed,
  input logic signed [fisp_pkg::DUTY_W-1:0] duty_out
);

  localparam logic signed [fisp_pkg::DUTY_W-1:0] DUTY_MAX =
    fisp_pkg::DUTY_W'(DUTY_FULL_SCALE);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(filtered_speed) && $stable(duty_out))
    else $error("result changed while stalled");

  // the block is busy right after taking a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // duty never leaves full scale
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (duty_out <= DUTY_MAX) && (duty_out >= -DUTY_MAX))
    else $error("duty out of range");

  // no result right after reset
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind filtered_incremental_speed_pid fisp_checker #(
  .DUTY_FULL_SCALE(DUTY_FULL_SCALE)
) u_fisp_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .filtered_speed (filtered_speed),
  .duty_out       (duty_out)
);
